[rtl/msfd_pkg.sv]
package msfd_pkg;

    // Character that closes a message on its own.
    localparam logic [6:0] CHAR_CR = 7'd13;

    // Frame layout: start bit, data bits, parity bit, stop bit.
    localparam int unsigned DATA_BITS = 7;
    localparam logic [3:0] POS_START  = 4'd0;
    localparam logic [3:0] POS_PARITY = 4'(DATA_BITS + 1);
    localparam logic [3:0] POS_STOP   = 4'(DATA_BITS + 2);
    localparam logic       STOP_LEVEL = 1'b1;

    // Reset value of the message byte limit.
    localparam logic [7:0] LIMIT_RESET = 8'd64;

    // Frame status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_START_ERR  = 2'd1;
    localparam logic [1:0] ST_PARITY_ERR = 2'd2;
    localparam logic [1:0] ST_STOP_ERR   = 2'd3;

endpackage

[rtl/meter_serial_frame_deframer_top.sv]
// Deframer for a meter serial data line: start bit, seven data bits LSB first,
// an even parity bit and a stop bit.
// The slave stream carries one sampled line bit per transaction. The master
// stream carries one result per frame: the character in tdata, the frame status
// in tuser and a message end mark in tlast. A bad start bit gives an error result
// after one bit, a parity error after nine bits and a stop error after ten.
// The config channel writes the message byte limit; it is always ready.
// Throughput is one bit per cycle unless the output side stalls. A result
// appears on the master side in the cycle after the bit transaction that
// completes the frame; frame state and output register update on one clock edge.
// The output register decouples the two sides: a new bit is taken whenever the
// output register is empty or is being drained in the same cycle. If the
// receiver stalls with a result pending, s_tready drops until it is taken.
// Reset clears the frame state and message count, empties the output register
// and loads the byte limit with 64.
module meter_serial_frame_deframer_top
    import msfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] data_bit, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_value, [7] zero
    output logic [1:0] m_tuser,   // [1:0] frame_status
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] limit_reg;
    logic [3:0] bit_pos_reg, bit_pos_next;
    logic [6:0] shift_reg, shift_next;
    logic       parity_reg, parity_next;
    logic [7:0] bytes_reg, bytes_next;

    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic [1:0] out_status_reg;
    logic       out_last_reg;

    logic       s_fire;
    logic       in_bit;
    logic [3:0] pos;
    logic       emit;
    logic [6:0] emit_char;
    logic [1:0] emit_status;
    logic [8:0] count;
    logic       emit_last;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_bit    = s_tdata[0];
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Unreachable positions fall back to awaiting the start bit.
    assign pos = (bit_pos_reg > POS_STOP) ? POS_START : bit_pos_reg;

    // Per-bit frame decode.
    always_comb
    begin
        bit_pos_next = pos;
        shift_next   = shift_reg;
        parity_next  = parity_reg;
        emit         = 1'b0;
        emit_char    = 7'd0;
        emit_status  = ST_OK;
        if (pos == POS_START)
        begin
            if (in_bit)
            begin
                emit        = 1'b1;
                emit_status = ST_START_ERR;
            end
            else
            begin
                shift_next   = 7'd0;
                parity_next  = 1'b0;
                bit_pos_next = 4'd1;
            end
        end
        else if (pos < POS_PARITY)
        begin
            if (in_bit)
            begin
                shift_next  = shift_reg | (7'd1 << (pos[2:0] - 3'd1));
                parity_next = !parity_reg;
            end
            bit_pos_next = pos + 4'd1;
        end
        else if (pos == POS_PARITY)
        begin
            if (in_bit != parity_reg)
            begin
                emit        = 1'b1;
                emit_status = ST_PARITY_ERR;
            end
            else
            begin
                bit_pos_next = pos + 4'd1;
            end
        end
        else
        begin
            emit = 1'b1;
            if (in_bit != STOP_LEVEL)
            begin
                emit_status = ST_STOP_ERR;
            end
            else
            begin
                emit_char = shift_reg;
            end
        end

        // Every result ends the frame.
        if (emit)
        begin
            bit_pos_next = POS_START;
            shift_next   = 7'd0;
            parity_next  = 1'b0;
        end
    end

    // Message counting and end mark.
    always_comb
    begin
        count     = {1'b0, bytes_reg} + 9'd1;
        emit_last = ((emit_status == ST_OK) && (emit_char == CHAR_CR))
                    || (count >= {1'b0, limit_reg});
        bytes_next = bytes_reg;
        if (emit)
        begin
            bytes_next = emit_last ? 8'd0 : count[7:0];
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Frame and message state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= POS_START;
            shift_reg   <= 7'd0;
            parity_reg  <= 1'b0;
            bytes_reg   <= 8'd0;
        end
        else if (s_fire)
        begin
            bit_pos_reg <= bit_pos_next;
            shift_reg   <= shift_next;
            parity_reg  <= parity_next;
            bytes_reg   <= bytes_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (s_fire && emit)
        begin
            out_char_reg   <= emit_char;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    // An error result never carries a character.
    a_err_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 8'd0))
        else $error("error result carries a nonzero character");

    // The bit position never leaves the frame layout.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= POS_STOP)
        else $error("bit position out of range");

    // A result that closes a message clears the count.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && emit && emit_last) |=> (bytes_reg == 8'd0))
        else $error("message count not cleared after last result");

    // A high start bit gives a start error result in the next cycle.
    a_start_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (pos == POS_START) && in_bit)
        |=> (m_tvalid && (m_tuser == ST_START_ERR)))
        else $error("start bit error not reported");

endmodule
